// ----- src/crcfpr_pkg.sv -----
// Package for the CRC framed packet receiver.
// Holds the parse phase and result kind types, the result struct, frame constants
// and the byte-wide CRC-16/MODBUS update. No dependencies.
package crcfpr_pkg;

    localparam logic [7:0]  HEAD_FIRST      = 8'hFE;
    localparam logic [7:0]  HEAD_SECOND     = 8'hEF;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [16:0] IDLE_MAX        = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam int          APB_ADDR_W      = 3;
    localparam int          APB_DATA_W      = 32;
    localparam logic [APB_ADDR_W-3:0] REG_FRAME_TIMEOUT = '0;

    typedef enum logic [2:0] {
        PH_HEAD  = 3'd0,
        PH_CMD   = 3'd1,
        PH_SUB   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [7:0] command;
        logic [7:0] sub_command;
        logic [7:0] payload_length;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/crcfpr_if.sv -----
// Valid/ready channel interfaces for the CRC framed packet receiver.
// Depends on crcfpr_pkg for the result kind type.
interface crcfpr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface crcfpr_out_if;
    logic                valid;
    logic                ready;
    crcfpr_pkg::t_kind   kind;
    logic [7:0]          data_byte;
    logic [7:0]          data_index;
    logic [7:0]          command;
    logic [7:0]          sub_command;
    logic [7:0]          payload_length;

    modport source (output valid, output kind, output data_byte, output data_index,
                    output command, output sub_command, output payload_length,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input data_index,
                  input command, input sub_command, input payload_length,
                  output ready);
endinterface

// ----- src/crc_framed_packet_receiver.sv -----
// Receiver for serial frames of head 0xFE 0xEF, cmd, subcmd, length, data and a CRC-16/MODBUS
// check. One byte or tick transfer is taken per clock while the input is not stalled; an
// accepted transfer is held in the input register, is parsed by the single-pass CRC and phase
// logic, and its result is registered in the output register (or the skid register) before it
// is offered. While the output is held off, the one-entry skid register takes one more result,
// after which the input stalls. The timeout is set through the APB register at offset 0.
module crc_framed_packet_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    crcfpr_in_if.sink                         i_in,
    crcfpr_out_if.source                      o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crcfpr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crcfpr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crcfpr_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);
    logic                r_in_valid;
    logic                r_in_mode;
    logic [7:0]          r_in_byte;
    logic                fire;
    logic                room;
    logic                res_valid;
    logic [15:0]         frame_timeout;
    crcfpr_pkg::t_result res;
    crcfpr_pkg::t_result out_data;

    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_mode <= i_in.mode;
            r_in_byte <= i_in.rx_byte;
        end
    end

    crcfpr_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_frame_timeout (frame_timeout)
    );

    crcfpr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_mode          (r_in_mode),
        .i_rx_byte       (r_in_byte),
        .i_frame_timeout (frame_timeout),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    crcfpr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_data  (out_data),
        .i_ready (o_out.ready)
    );

    assign o_out.kind           = out_data.kind;
    assign o_out.data_byte      = out_data.data_byte;
    assign o_out.data_index     = out_data.data_index;
    assign o_out.command        = out_data.command;
    assign o_out.sub_command    = out_data.sub_command;
    assign o_out.payload_length = out_data.payload_length;
endmodule

// ----- src/crcfpr_apb_regs.sv -----
// APB configuration register file holding the frame timeout.
// Depends on crcfpr_pkg for address and data widths and the reset value.
module crcfpr_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crcfpr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crcfpr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crcfpr_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output logic [15:0]                       o_frame_timeout
);
    logic        hit;
    logic [15:0] r_frame_timeout;

    assign hit = paddr[crcfpr_pkg::APB_ADDR_W-1:2] == crcfpr_pkg::REG_FRAME_TIMEOUT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_timeout <= crcfpr_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_frame_timeout <= pwdata[15:0];
        end
    end

    assign pready          = 1'b1;
    assign prdata          = hit ? {16'h0000, r_frame_timeout} : '0;
    assign o_frame_timeout = r_frame_timeout;
endmodule

// ----- src/crcfpr_parser.sv -----
// Frame parser: head hunt, header capture, running CRC, data and end-of-frame results.
// Depends on crcfpr_pkg for the phase type, constants and the CRC update.
module crcfpr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_mode,
    input  logic [7:0]          i_rx_byte,
    input  logic [15:0]         i_frame_timeout,
    output logic                o_res_valid,
    output crcfpr_pkg::t_result o_res
);
    crcfpr_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [1:0]  r_head_matched, n_head_matched, cur_matched;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_sub, n_sub;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_check_high, n_check_high;
    logic        r_check_count, n_check_count;
    logic [16:0] r_idle, n_idle;
    logic [15:0] crc_upd;
    logic [7:0]  count_inc;
    logic [7:0]  head_expect;

    assign crc_upd   = crcfpr_pkg::crc_byte(r_crc, i_rx_byte);
    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase        = r_phase;
        n_head_matched = r_head_matched;
        n_cmd          = r_cmd;
        n_sub          = r_sub;
        n_len          = r_len;
        n_count        = r_count;
        n_crc          = r_crc;
        n_check_high   = r_check_high;
        n_check_count  = r_check_count;
        n_idle         = r_idle;
        o_res_valid    = 1'b0;
        o_res          = '{kind: crcfpr_pkg::KIND_DATA, data_byte: i_rx_byte,
                           data_index: r_count, command: r_cmd, sub_command: r_sub,
                           payload_length: r_len};
        cur_phase      = r_phase;
        cur_matched    = r_head_matched;
        head_expect    = crcfpr_pkg::HEAD_FIRST;
        if (i_fire) begin
            if (i_mode) begin
                if (r_idle < crcfpr_pkg::IDLE_MAX) begin
                    n_idle = r_idle + 17'd1;
                end
            end else begin
                if (r_idle > {1'b0, i_frame_timeout}) begin
                    cur_phase   = crcfpr_pkg::PH_HEAD;
                    cur_matched = 2'd0;
                    n_phase        = crcfpr_pkg::PH_HEAD;
                    n_head_matched = 2'd0;
                end
                n_idle = '0;
                unique case (cur_phase)
                    crcfpr_pkg::PH_HEAD: begin
                        head_expect = (cur_matched == 2'd0) ? crcfpr_pkg::HEAD_FIRST
                                                            : crcfpr_pkg::HEAD_SECOND;
                        if (cur_matched < 2'd2 && i_rx_byte == head_expect) begin
                            n_head_matched = cur_matched + 2'd1;
                            if (cur_matched == 2'd1) begin
                                n_phase = crcfpr_pkg::PH_CMD;
                                n_crc   = crcfpr_pkg::CRC_INIT;
                            end
                        end else begin
                            n_head_matched = 2'd0;
                        end
                    end
                    crcfpr_pkg::PH_CMD: begin
                        n_cmd   = i_rx_byte;
                        n_crc   = crc_upd;
                        n_phase = crcfpr_pkg::PH_SUB;
                    end
                    crcfpr_pkg::PH_SUB: begin
                        n_sub   = i_rx_byte;
                        n_crc   = crc_upd;
                        n_phase = crcfpr_pkg::PH_LEN;
                    end
                    crcfpr_pkg::PH_LEN: begin
                        n_len = i_rx_byte;
                        n_crc = crc_upd;
                        if (i_rx_byte == 8'd0) begin
                            n_phase       = crcfpr_pkg::PH_CHECK;
                            n_check_count = 1'b0;
                        end else begin
                            n_phase = crcfpr_pkg::PH_DATA;
                            n_count = 8'd0;
                        end
                    end
                    crcfpr_pkg::PH_DATA: begin
                        n_crc   = crc_upd;
                        n_count = count_inc;
                        if (count_inc >= r_len || count_inc == 8'd0) begin
                            n_phase       = crcfpr_pkg::PH_CHECK;
                            n_check_count = 1'b0;
                        end
                        o_res_valid = 1'b1;
                    end
                    crcfpr_pkg::PH_CHECK: begin
                        if (!r_check_count) begin
                            n_check_high  = i_rx_byte;
                            n_check_count = 1'b1;
                        end else begin
                            n_check_count    = 1'b0;
                            o_res_valid      = 1'b1;
                            o_res.kind       = ({r_check_high, i_rx_byte} == r_crc)
                                               ? crcfpr_pkg::KIND_GOOD
                                               : crcfpr_pkg::KIND_BAD;
                            o_res.data_byte  = 8'd0;
                            o_res.data_index = 8'd0;
                            n_phase          = crcfpr_pkg::PH_HEAD;
                            n_head_matched   = 2'd0;
                        end
                    end
                    default: begin
                        n_phase        = crcfpr_pkg::PH_HEAD;
                        n_head_matched = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= crcfpr_pkg::PH_HEAD;
            r_head_matched <= '0;
            r_cmd          <= '0;
            r_sub          <= '0;
            r_len          <= '0;
            r_count        <= '0;
            r_crc          <= crcfpr_pkg::CRC_INIT;
            r_check_high   <= '0;
            r_check_count  <= 1'b0;
            r_idle         <= '0;
        end else begin
            r_phase        <= n_phase;
            r_head_matched <= n_head_matched;
            r_cmd          <= n_cmd;
            r_sub          <= n_sub;
            r_len          <= n_len;
            r_count        <= n_count;
            r_crc          <= n_crc;
            r_check_high   <= n_check_high;
            r_check_count  <= n_check_count;
            r_idle         <= n_idle;
        end
    end

`ifndef ASSERT_OFF
    a_res_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_fire && !i_mode))
        else $error("result raised without an accepted byte");
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == crcfpr_pkg::PH_HEAD) |-> (r_head_matched != 2'd3))
        else $error("head match count out of range");
    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_mode) |=> (r_idle == 17'd0))
        else $error("idle counter not cleared by a byte");
`endif
endmodule

// ----- src/crcfpr_out_stage.sv -----
// Result register with a skid entry, decoupling the parser from output backpressure.
// Depends on crcfpr_pkg for the result struct.
module crcfpr_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  crcfpr_pkg::t_result i_data,
    output logic                o_room,
    output logic                o_valid,
    output crcfpr_pkg::t_result o_data,
    input  logic                i_ready
);
    logic                r_main_valid;
    logic                r_skid_valid;
    crcfpr_pkg::t_result r_main;
    crcfpr_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || i_ready) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

`ifndef ASSERT_OFF
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry holds a result while the output register is empty");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed with no room");
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !i_ready) |=> r_skid_valid)
        else $error("stalled result not captured in skid entry");
`endif
endmodule
